FILE: src/maf_pkg.sv
// Shared constants and types for the moving average filter.
`default_nettype none

package maf_pkg;

    localparam int WINDOW_DEPTH   = 256;
    localparam int SAMPLE_BITS    = 16;
    localparam int POS_BITS       = $clog2(WINDOW_DEPTH);
    localparam int EW_BITS        = POS_BITS + 1;
    localparam int SUM_BITS       = SAMPLE_BITS + POS_BITS;
    localparam int CNT_BITS       = $clog2(SUM_BITS + 1);
    localparam int CFG_WIDTH_BITS = 9;
    localparam int APB_ADDR_BITS  = 3;
    localparam int APB_DATA_BITS  = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int QPTR_BITS      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS      = $clog2(QUEUE_DEPTH + 1);

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW_WIDTH = 1'b0;

    localparam logic [CFG_WIDTH_BITS-1:0] WIDTH_RESET = CFG_WIDTH_BITS'(1);

    typedef struct packed {
        logic                          pass;
        logic signed [SAMPLE_BITS-1:0] sample;
    } t_item;

    typedef struct packed {
        logic               clr;
        logic [EW_BITS-1:0] width;
    } t_cfg;

endpackage

`default_nettype wire

FILE: src/maf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module maf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: src/maf_front.sv
// Front end: APB register, input acceptance and pass-through classification.
`default_nettype none

module maf_front import maf_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [SAMPLE_BITS-1:0]   i_sample,
    input  wire logic                     i_q_full,
    output logic                          o_push,
    output t_item                         o_item,
    output t_cfg                          o_cfg
);

    logic [CFG_WIDTH_BITS-1:0] r_width;
    logic [CFG_WIDTH_BITS-1:0] n_width;
    logic                      wr_sel;
    logic [EW_BITS-1:0]        eff_width;

    assign wr_sel  = psel && penable && pwrite && (paddr[2] == REG_WINDOW_WIDTH);
    assign n_width = wr_sel ? pwdata[CFG_WIDTH_BITS-1:0] : r_width;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width <= WIDTH_RESET;
        end else begin
            r_width <= n_width;
        end
    end

    // widths above the store depth saturate
    assign eff_width = (32'(r_width) > 32'(WINDOW_DEPTH)) ? EW_BITS'(WINDOW_DEPTH)
                                                         : EW_BITS'(r_width);

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_WINDOW_WIDTH) ? APB_DATA_BITS'(r_width)
                                                   : '0;

    assign o_stall       = i_q_full;
    assign o_push        = i_valid && !i_q_full;
    assign o_item.pass   = (eff_width < EW_BITS'(2));
    assign o_item.sample = i_sample;
    assign o_cfg.clr     = wr_sel;
    assign o_cfg.width   = eff_width;

endmodule

`default_nettype wire

FILE: src/maf_queue.sv
// Short request queue between front and back.
`default_nettype none

module maf_queue import maf_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);

    t_item                r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wptr;
    logic [QPTR_BITS-1:0] r_rptr;
    logic [QCNT_BITS-1:0] r_count;
    logic [QPTR_BITS-1:0] n_wptr;
    logic [QPTR_BITS-1:0] n_rptr;

    assign n_wptr = (32'(r_wptr) == QUEUE_DEPTH - 1) ? '0 : r_wptr + QPTR_BITS'(1);
    assign n_rptr = (32'(r_rptr) == QUEUE_DEPTH - 1) ? '0 : r_rptr + QPTR_BITS'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wptr] <= i_item;
                r_wptr        <= n_wptr;
            end
            if (i_pop) begin
                r_rptr <= n_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_BITS'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_BITS'(1);
            end
        end
    end

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];

endmodule

`default_nettype wire

FILE: src/maf_back.sv
// Back end: window store, running sum, serial divider and output register.
`default_nettype none

module maf_back import maf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_cfg                  i_cfg,
    input  wire logic                  i_q_valid,
    input  wire t_item                 i_q_item,
    output logic                       o_q_pop,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output logic [SAMPLE_BITS-1:0]     o_average
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ACC  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]                    r_state;
    logic signed [SUM_BITS-1:0]    r_sum;
    logic [POS_BITS-1:0]           r_pos;
    logic [WINDOW_DEPTH-1:0]       r_vld;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_neg;
    logic [SUM_BITS-1:0]           r_quo;
    logic [EW_BITS-1:0]            r_rem;
    logic [CNT_BITS-1:0]           r_cnt;
    logic                          r_out_valid;
    logic [SAMPLE_BITS-1:0]        r_out_avg;

    logic                          out_free;
    logic                          out_load;
    logic                          we;
    logic [SAMPLE_BITS-1:0]        rdata;
    logic signed [SAMPLE_BITS-1:0] old_smp;
    logic signed [SUM_BITS-1:0]    sum_new;
    logic [SUM_BITS-1:0]           mag;
    logic [EW_BITS-1:0]            pos_inc;
    logic [POS_BITS-1:0]           pos_next;
    logic [EW_BITS:0]              rem_sh;
    logic [EW_BITS:0]              rem_sub;
    logic                          ge;
    logic [SUM_BITS-1:0]           quo_signed;

    assign we = (r_state == ST_ACC);

    maf_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_pos),
        .i_wdata (r_sample),
        .i_raddr (r_pos),
        .o_rdata (rdata)
    );

    assign out_free = !r_out_valid || !i_stall;
    assign o_q_pop  = (r_state == ST_IDLE) && i_q_valid && !i_cfg.clr
                      && (!i_q_item.pass || out_free);
    // output register takes a new average this cycle
    assign out_load = ((r_state == ST_IDLE) && o_q_pop && i_q_item.pass)
                      || ((r_state == ST_OUT) && out_free);

    // entries never written since the last clear read as zero
    assign old_smp  = r_vld[r_pos] ? $signed(rdata) : '0;
    assign sum_new  = r_sum + SUM_BITS'(r_sample) - SUM_BITS'(old_smp);
    assign mag      = sum_new[SUM_BITS-1] ? SUM_BITS'(-sum_new) : SUM_BITS'(sum_new);
    assign pos_inc  = EW_BITS'(r_pos) + EW_BITS'(1);
    assign pos_next = (pos_inc >= i_cfg.width) ? '0 : pos_inc[POS_BITS-1:0];

    // restoring divide, one quotient bit per cycle
    assign rem_sh  = {r_rem, r_quo[SUM_BITS-1]};
    assign ge      = (rem_sh >= {1'b0, i_cfg.width});
    assign rem_sub = rem_sh - {1'b0, i_cfg.width};

    assign quo_signed = r_neg ? (~r_quo + SUM_BITS'(1)) : r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sum       <= '0;
            r_pos       <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (o_q_pop) begin
                        if (i_q_item.pass) begin
                            r_out_valid <= 1'b1;
                            r_out_avg   <= i_q_item.sample;
                        end else begin
                            r_sample <= i_q_item.sample;
                            r_state  <= ST_ACC;
                        end
                    end
                end
                ST_ACC: begin
                    if (!i_cfg.clr) begin
                        r_sum        <= sum_new;
                        r_vld[r_pos] <= 1'b1;
                        r_pos        <= pos_next;
                    end
                    r_neg        <= sum_new[SUM_BITS-1];
                    r_quo        <= mag;
                    r_rem        <= '0;
                    r_cnt        <= '0;
                    r_state      <= ST_DIV;
                end
                ST_DIV: begin
                    r_rem <= ge ? rem_sub[EW_BITS-1:0] : rem_sh[EW_BITS-1:0];
                    r_quo <= {r_quo[SUM_BITS-2:0], ge};
                    r_cnt <= r_cnt + CNT_BITS'(1);
                    if (r_cnt == CNT_BITS'(SUM_BITS - 1)) begin
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_avg   <= quo_signed[SAMPLE_BITS-1:0];
                        r_state     <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
            // width write clears the window
            if (i_cfg.clr) begin
                r_sum <= '0;
                r_pos <= '0;
                r_vld <= '0;
            end
        end
    end

    assign o_valid   = r_out_valid;
    assign o_average = r_out_avg;

`ifndef SYNTHESIS
    a_clr_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.clr |=> (r_sum == '0 && r_pos == '0 && r_vld == '0))
        else $error("window not cleared after width write");

    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV && r_cnt == CNT_BITS'(SUM_BITS - 1)) |=> (r_state == ST_OUT))
        else $error("divider did not finish after full step count");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && out_free) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished average not presented");
`endif

endmodule

`default_nettype wire

FILE: src/moving_average_filter_top.sv
// Top level of the moving average filter: front end, request queue, back end.
// Averaged requests go one at a time through queue pop, sum update, 24-step divide and
//   output load; pass-through requests (width 0 or 1) skip the divide.
// Averaged throughput is set by the radix-2 serial divider over the 24-bit running sum;
//   pass-through requests one per cycle while the output is not stalled.
// Reset (synchronous, i_rst_n low): width returns to 1, running sum, write position
//   and window valid bits clear at once; no clearing pass, the block is ready next cycle.
`default_nettype none

module moving_average_filter_top import maf_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // APB register port
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [APB_ADDR_BITS-1:0] paddr,
    input  wire logic [APB_DATA_BITS-1:0] pwdata,
    output logic      [APB_DATA_BITS-1:0] prdata,
    output logic                          pready,
    // sample input channel
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [SAMPLE_BITS-1:0]   i_sample,
    // average output channel
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic      [SAMPLE_BITS-1:0]   o_average
);

    // front to queue
    logic  push;
    t_item push_item;
    logic  q_full;
    // queue to back
    logic  q_valid;
    logic  q_pop;
    t_item q_item;
    // effective width and clear strobe
    t_cfg  cfg;

    // Front: holds window_width, saturates it to the store depth and tags each
    // request as pass-through or averaged before it enters the queue.
    maf_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_sample (i_sample),
        .i_q_full (q_full),
        .o_push   (push),
        .o_item   (push_item),
        .o_cfg    (cfg)
    );

    // Two-entry queue lets the front keep taking requests while the divider runs.
    maf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Back: ring store in RAM, running sum, serial divide, registered output.
    // The output register frees the back end as soon as a result is parked.
    maf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_average (o_average)
    );

endmodule

`default_nettype wire

FILE: sim/testbench.sv
// Self-checking testbench for the moving average filter: random traffic, APB setup, scoreboard.

module testbench;
    import maf_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 6;
    localparam int DRAIN_CYCLES   = 40;
    localparam int TIMEOUT_CYCLES = 1_000_000;
    localparam int TARGET_ITEMS   = 1900;
    localparam int HOLD_CYCLES    = 400;       // long receiver hold-off
    localparam int HOLD_EVERY     = 600;       // results between hold-offs

    localparam logic [APB_ADDR_BITS-1:0] ADDR_WINDOW_WIDTH = APB_ADDR_BITS'(0);
    localparam logic [APB_ADDR_BITS-1:0] ADDR_SPARE        = APB_ADDR_BITS'(4);

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    typedef enum int {MIX_FULL, MIX_RAIL, MIX_SMALL, MIX_EDGE} t_sample_mix;
    typedef enum int {RX_OPEN, RX_LIGHT, RX_HALF, RX_HEAVY} t_rx_mode;

    // DUT connections, all inputs known from time zero
    logic                     i_clk   = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     psel    = 1'b0;
    logic                     penable = 1'b0;
    logic                     pwrite  = 1'b0;
    logic [APB_ADDR_BITS-1:0] paddr   = '0;
    logic [APB_DATA_BITS-1:0] pwdata  = '0;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     i_valid  = 1'b0;
    logic                     o_stall;
    logic [SAMPLE_BITS-1:0]   i_sample = '0;
    logic                     o_valid;
    logic                     i_stall  = 1'b0;
    logic [SAMPLE_BITS-1:0]   o_average;

    moving_average_filter_top u_top (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .i_valid   (i_valid),
        .o_stall   (o_stall),
        .i_sample  (i_sample),
        .o_valid   (o_valid),
        .i_stall   (i_stall),
        .o_average (o_average)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Filter state mirror
    logic [CFG_WIDTH_BITS-1:0]     cfg_width;
    longint                        win_sum;
    int unsigned                   win_pos;
    logic signed [SAMPLE_BITS-1:0] win_samples [WINDOW_DEPTH];

    logic [SAMPLE_BITS-1:0] queued_samples [$];
    logic [SAMPLE_BITS-1:0] expected_averages [$];
    int                     fail_count = 0;

    function automatic void flush_window();
        win_sum = 0;
        win_pos = 0;
        for (int k = 0; k < WINDOW_DEPTH; k++) win_samples[k] = '0;
    endfunction

    // Advance the window by one sample and return the truncated average.
    function automatic logic [SAMPLE_BITS-1:0] next_average(input logic [SAMPLE_BITS-1:0] raw);
        logic signed [SAMPLE_BITS-1:0] s;
        int unsigned                   w;
        longint                        q;
        s = raw;
        w = (cfg_width > WINDOW_DEPTH) ? WINDOW_DEPTH : cfg_width;
        if (w < 2) return raw;   // pass-through, state untouched
        if (win_pos >= w) win_pos = 0;
        win_sum = win_sum + (longint'(s) - longint'(win_samples[win_pos]));
        win_samples[win_pos] = s;
        win_pos = win_pos + 1;
        if (win_pos >= w) win_pos = 0;
        q = win_sum / longint'(w);   // SV division truncates toward zero
        return q[SAMPLE_BITS-1:0];
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] gen_sample(input t_sample_mix mix);
        case (mix)
            MIX_RAIL: begin
                if ($urandom_range(0, 7) == 0) return SAMPLE_BITS'($urandom);
                return $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
            end
            MIX_SMALL: return SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
            MIX_EDGE: begin
                case ($urandom_range(0, 5))
                    0: return SAMPLE_MAX;
                    1: return SAMPLE_MIN;
                    2: return '1;
                    3: return '0;
                    4: return SAMPLE_BITS'(1);
                    default: return SAMPLE_MAX - 1'b1;
                endcase
            end
            default: return SAMPLE_BITS'($urandom);
        endcase
    endfunction

    // APB write: setup then access; mirror updates once the access completes
    task automatic write_reg(input logic [APB_ADDR_BITS-1:0] addr,
                             input logic [APB_DATA_BITS-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr[2] == REG_WINDOW_WIDTH) begin
            cfg_width = data[CFG_WIDTH_BITS-1:0];
            flush_window();
        end
    endtask

    // Block is idle once every request went in and every average came back
    task automatic wait_idle();
        while (queued_samples.size() != 0 || expected_averages.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic queue_samples(input logic [SAMPLE_BITS-1:0] vals [$]);
        foreach (vals[k]) queued_samples.push_back(vals[k]);
    endtask

    // Request driver: bursts of random length separated by random gaps
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin : drive_requests
        logic took;
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            burst_left <= 0;
            gap_left   <= 0;
        end else begin
            took = i_valid && !o_stall;
            if (took) begin
                expected_averages.push_back(next_average(i_sample));
                void'(queued_samples.pop_front());
            end
            if (i_valid && !took) begin
                // stalled: hold valid and payload
            end else if (gap_left != 0) begin
                gap_left <= gap_left - 1;
                i_valid  <= 1'b0;
            end else if (queued_samples.size() != 0) begin
                i_valid  <= 1'b1;
                i_sample <= queued_samples[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? $urandom_range(5, 60)
                                                              : $urandom_range(0, 2);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // Receiver stall pattern, with a periodic long hold-off so the block backs up
    t_rx_mode    rx_mode      = RX_OPEN;
    int unsigned mode_left    = 0;
    int unsigned hold_left    = 0;
    int unsigned results_seen = 0;
    int unsigned next_hold_at = HOLD_EVERY / 2;

    always @(posedge i_clk) begin : drive_stall
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) results_seen <= results_seen + 1;
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                i_stall   <= (hold_left != 1);
            end else if (results_seen >= next_hold_at) begin
                hold_left    <= HOLD_CYCLES;
                next_hold_at <= next_hold_at + HOLD_EVERY;
                i_stall      <= 1'b1;
            end else begin
                if (mode_left == 0) begin
                    rx_mode   <= t_rx_mode'($urandom_range(0, 3));
                    mode_left <= $urandom_range(10, 200);
                end else begin
                    mode_left <= mode_left - 1;
                end
                case (rx_mode)
                    RX_OPEN:  i_stall <= 1'b0;
                    RX_LIGHT: i_stall <= ($urandom_range(0, 3) == 0);
                    RX_HALF:  i_stall <= ($urandom_range(0, 1) == 1);
                    default:  i_stall <= ($urandom_range(0, 9) != 0);
                endcase
            end
        end
    end

    // Scoreboard: in-order compare against predicted averages
    always @(posedge i_clk) begin : check_averages
        logic [SAMPLE_BITS-1:0] want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_averages.size() == 0) begin
                $error("average: expected none, actual %0d", $signed(o_average));
                fail_count++;
            end else begin
                want = expected_averages.pop_front();
                if (o_average !== want) begin
                    $error("average: expected %0d, actual %0d", $signed(want),
                           $signed(o_average));
                    fail_count++;
                end
            end
        end
    end

    // Stimulus sequence
    initial begin : run_sequence
        int unsigned                   total_items;
        int unsigned                   w;
        int unsigned                   ew;
        int unsigned                   n;
        int unsigned                   phase;
        t_sample_mix                   mix;
        logic [SAMPLE_BITS-1:0]        batch [$];
        int unsigned                   corner_widths [7];

        corner_widths = '{0, 1, 2, 255, 256, 257, 511};
        cfg_width     = WIDTH_RESET;
        flush_window();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: pass-through at the reset width, field extremes
        queue_samples('{16'h0000, SAMPLE_MAX, SAMPLE_MIN, 16'hFFFF, 16'h0001});
        wait_idle();
        // width zero also passes through
        write_reg(ADDR_WINDOW_WIDTH, 32'd0);
        queue_samples('{SAMPLE_MAX, SAMPLE_MIN});
        wait_idle();
        // width 2: full-scale sums and truncation toward zero on odd negative sums
        write_reg(ADDR_WINDOW_WIDTH, 32'd2);
        queue_samples('{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MIN, 16'hFFFF, 16'h0000});
        wait_idle();
        // unmapped register: must not clear the window
        write_reg(ADDR_SPARE, 32'hFFFF_FFFF);
        queue_samples('{16'h0001});
        wait_idle();
        // width above depth saturates; high data bits ignored
        write_reg(ADDR_WINDOW_WIDTH, 32'hFFFF_FE00 | 32'd300);
        queue_samples('{SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX});
        wait_idle();
        write_reg(ADDR_WINDOW_WIDTH, 32'd3);
        queue_samples('{16'h0005, 16'hFFFB, 16'h0001});
        wait_idle();
        total_items = 22;

        // Random phases: corner widths first, then a random mix
        phase = 0;
        while (total_items < TARGET_ITEMS) begin
            if (phase < 7) begin
                w = corner_widths[phase];
            end else begin
                case ($urandom_range(0, 9))
                    0:       w = $urandom_range(0, 1);
                    1:       w = $urandom_range(257, 511);
                    2, 3:    w = $urandom_range(17, 256);
                    default: w = $urandom_range(2, 16);
                endcase
            end
            if ($urandom_range(0, 5) == 0) write_reg(ADDR_SPARE, $urandom);
            write_reg(ADDR_WINDOW_WIDTH, ($urandom & ~32'h1FF) | w);

            case ($urandom_range(0, 4))
                0:       mix = MIX_RAIL;
                1:       mix = MIX_EDGE;
                2:       mix = MIX_SMALL;
                default: mix = MIX_FULL;
            endcase
            ew = (w > WINDOW_DEPTH) ? WINDOW_DEPTH : w;
            // rail phases run past a full window to push the sum to its limits
            if (mix == MIX_RAIL) n = ((ew < 2) ? 30 : ew) + $urandom_range(5, 40);
            else                 n = $urandom_range(10, 120);

            batch.delete();
            repeat (n) batch.push_back(gen_sample(mix));
            queue_samples(batch);
            wait_idle();
            total_items += n;
            phase++;
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(CLK_PERIOD * TIMEOUT_CYCLES);
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
src/maf_pkg.sv
src/maf_ram.sv
src/maf_front.sv
src/maf_queue.sv
src/maf_back.sv
src/moving_average_filter_top.sv
sim/testbench.sv
